// ----- design/wsq_pkg.sv -----
package wsq_pkg;

   localparam int DEPTH  = 16;
   localparam int OCC_W  = $clog2(DEPTH + 1);

   localparam int ELEM_W    = 32;
   localparam int GRADE_W   = 10;
   localparam int COURSES_W = 8;
   localparam int FRAC_W    = 16;
   localparam int PRIO_W    = FRAC_W + 1;
   localparam int DIV_W     = GRADE_W;
   localparam int DIV_CNT_W = $clog2(PRIO_W + 1);

   localparam int REQ_FIELDS_W = 2 + ELEM_W + GRADE_W + COURSES_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ELEM_W + GRADE_W + COURSES_W + PRIO_W + OCC_W + 1 + 2;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = GRADE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADE_SCALE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COURSE_SCALE = 1'd1;

   localparam logic [GRADE_W-1:0]   GRADE_SCALE_RESET  = 10'd1000;
   localparam logic [COURSES_W-1:0] COURSE_SCALE_RESET = 8'd30;

   localparam logic [1:0] ACT_ENQ   = 2'd0;
   localparam logic [1:0] ACT_DEQ   = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]           action;
      logic [ELEM_W-1:0]    elem;
      logic [GRADE_W-1:0]   grade;
      logic [COURSES_W-1:0] courses;
      logic [PRIO_W-1:0]    prio;
   } cmd_type;

   typedef struct packed {
      logic [ELEM_W-1:0]    elem;
      logic [GRADE_W-1:0]   grade;
      logic [COURSES_W-1:0] courses;
      logic [PRIO_W-1:0]    prio;
   } slot_type;

   typedef struct packed {
      logic [ELEM_W-1:0]    front_elem;
      logic [GRADE_W-1:0]   front_grade;
      logic [COURSES_W-1:0] front_courses;
      logic [PRIO_W-1:0]    front_priority;
      logic [OCC_W-1:0]     entry_count;
      logic                 is_empty;
      logic [1:0]           status;
   } rsp_type;

endpackage

// ----- design/wsq_div.sv -----
module wsq_div import wsq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  num,
   input  logic [DIV_W-1:0]  den,
   output logic              busy,
   output logic [PRIO_W-1:0] quo
);

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     den_ff;
   logic [PRIO_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 zero_ff;
   logic [DIV_W:0]       shifted;
   logic                 take;

   // num <= den, so the first step yields the integer bit without a shift
   always_comb begin
      shifted = (cnt_ff == DIV_CNT_W'(PRIO_W)) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      take    = shifted >= {1'b0, den_ff};
      rem_in  = take ? DIV_W'(shifted - {1'b0, den_ff}) : shifted[DIV_W-1:0];
      quo_in  = {quo_ff[PRIO_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_CNT_W'(PRIO_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num;
         den_ff  <= den;
         zero_ff <= (den == '0);
         quo_ff  <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quo  = zero_ff ? '0 : quo_ff;

endmodule

// ----- design/wsq_front.sv -----
module wsq_front import wsq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           action,
   input  logic [ELEM_W-1:0]    elem_value,
   input  logic [GRADE_W-1:0]   grade_in,
   input  logic [COURSES_W-1:0] courses_in,
   input  logic [GRADE_W-1:0]   grade_scale,
   input  logic [COURSES_W-1:0] course_scale,
   output logic                 push_valid,
   input  logic                 push_ready,
   output cmd_type              push_cmd
);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_type;

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic [GRADE_W-1:0]   grade_clamp;
   logic [COURSES_W-1:0] courses_clamp;
   logic                 accept;
   logic                 start;
   logic                 busy_g, busy_c;
   logic [PRIO_W-1:0]    quo_g, quo_c;
   logic [PRIO_W:0]      prio_sum;

   always_comb begin
      grade_clamp   = (grade_in > grade_scale) ? grade_scale : grade_in;
      courses_clamp = (courses_in > course_scale) ? course_scale : courses_in;
      accept        = req_valid && (state_ff == F_IDLE);
      start         = accept && (action == ACT_ENQ);
      prio_sum      = {1'b0, quo_g} + {1'b0, quo_c};
   end

   wsq_div u_div_grade (
      .clock (clock),
      .reset (reset),
      .start (start),
      .num   (grade_clamp),
      .den   (grade_scale),
      .busy  (busy_g),
      .quo   (quo_g)
   );

   wsq_div u_div_courses (
      .clock (clock),
      .reset (reset),
      .start (start),
      .num   (DIV_W'(courses_clamp)),
      .den   (DIV_W'(course_scale)),
      .busy  (busy_c),
      .quo   (quo_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  cmd_ff.action  <= action;
                  cmd_ff.elem    <= elem_value;
                  cmd_ff.grade   <= grade_clamp;
                  cmd_ff.courses <= courses_clamp;
                  cmd_ff.prio    <= '0;
                  state_ff       <= start ? F_DIV : F_PUSH;
               end
            end
            F_DIV: begin
               if (!busy_g && !busy_c) begin
                  cmd_ff.prio <= prio_sum[PRIO_W:1];
                  state_ff    <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_cmd   = cmd_ff;

endmodule

// ----- design/wsq_fifo.sv -----
module wsq_fifo import wsq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/wsq_back.sv -----
module wsq_back import wsq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp,
   output logic [OCC_W-1:0] occupancy
);

   slot_type         slot_ff [DEPTH];
   slot_type         slot_in [DEPTH];
   slot_type         fresh;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [DEPTH-1:0] ahead;
   logic [1:0]       status;
   logic             take;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      fresh.elem    = cmd.elem;
      fresh.grade   = cmd.grade;
      fresh.courses = cmd.courses;
      fresh.prio    = cmd.prio;
      // entries that stay in front of the new one; the list is sorted, so a prefix
      for (int i = 0; i < DEPTH; i++) begin
         ahead[i] = (OCC_W'(i) < occ_ff) && (slot_ff[i].prio >= cmd.prio);
      end
   end

   always_comb begin
      slot_in = slot_ff;
      occ_in  = occ_ff;
      status  = ST_OK;
      if (take) begin
         unique case (cmd.action)
            ACT_ENQ: begin
               if (occ_ff == OCC_W'(DEPTH)) begin
                  status = ST_FULL;
               end else begin
                  if (!ahead[0]) begin
                     slot_in[0] = fresh;
                  end
                  for (int i = 1; i < DEPTH; i++) begin
                     if (!ahead[i]) begin
                        slot_in[i] = ahead[i-1] ? fresh : slot_ff[i-1];
                     end
                  end
                  occ_in = occ_ff + OCC_W'(1);
               end
            end
            ACT_DEQ: begin
               if (occ_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     slot_in[i] = slot_ff[i+1];
                  end
                  occ_in = occ_ff - OCC_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (occ_in != '0) begin
         rsp_in.front_elem     = slot_in[0].elem;
         rsp_in.front_grade    = slot_in[0].grade;
         rsp_in.front_courses  = slot_in[0].courses;
         rsp_in.front_priority = slot_in[0].prio;
      end else begin
         rsp_in.front_elem     = '0;
         rsp_in.front_grade    = '0;
         rsp_in.front_courses  = '0;
         rsp_in.front_priority = '0;
      end
      rsp_in.entry_count = occ_in;
      rsp_in.is_empty    = (occ_in == '0);
      rsp_in.status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign occupancy = occ_ff;

endmodule

// ----- design/weighted_score_priority_queue_core.sv -----
// Bounded priority queue of 16 entries ordered by a score, the mean of
// grade/grade_scale and courses/course_scale in unsigned Q1.16, ties first in,
// first out. Every request gives one response with the front entry, the entry
// count and a status. An enqueue computes its score in the front end: two 17-step
// shift-subtract dividers run one quotient bit per cycle, then the front end forms
// the score and hands the command over, and the back end updates the store. The front
// end holds one request at a time and accepts the next once it has handed its
// command to the two-deep command queue; the sorted store in the back end shifts
// its entries in parallel to insert or remove one. Write the registers only while idle.
module weighted_score_priority_queue_core import wsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // action[1:0], elem_value[33:2], grade_in[43:34], courses_in[51:44], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // front_elem[31:0], front_grade[41:32], front_courses[49:42],
   // front_priority[66:50], entry_count[71:67], is_empty[72], status[74:73], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [GRADE_W-1:0]   grade_scale_ff;
   logic [COURSES_W-1:0] course_scale_ff;
   logic                 push_valid, push_ready;
   cmd_type              push_cmd;
   logic                 pop_valid, pop_ready;
   cmd_type              pop_cmd;
   rsp_type              rsp;
   logic [OCC_W-1:0]     occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         grade_scale_ff  <= GRADE_SCALE_RESET;
         course_scale_ff <= COURSE_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GRADE_SCALE:  grade_scale_ff  <= csr_wdata;
            CSR_COURSE_SCALE: course_scale_ff <= csr_wdata[COURSES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   wsq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .action       (req_tdata[1:0]),
      .elem_value   (req_tdata[2 +: ELEM_W]),
      .grade_in     (req_tdata[2 + ELEM_W +: GRADE_W]),
      .courses_in   (req_tdata[2 + ELEM_W + GRADE_W +: COURSES_W]),
      .grade_scale  (grade_scale_ff),
      .course_scale (course_scale_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_cmd     (push_cmd)
   );

   wsq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   wsq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .occupancy (occupancy)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.status, rsp.is_empty, rsp.entry_count,
                       rsp.front_priority, rsp.front_courses, rsp.front_grade,
                       rsp.front_elem};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(DEPTH))
      else $error("entry count above depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status == ST_FULL) |-> rsp.entry_count == OCC_W'(DEPTH))
      else $error("full status while queue not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status == ST_EMPTY) |-> rsp.is_empty && rsp.entry_count == '0)
      else $error("empty status while queue holds entries");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.is_empty |-> rsp.front_priority == '0 && rsp.front_elem == '0)
      else $error("empty queue reports a front entry");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("front end took a request while busy");

endmodule

// ----- tb/sv/tb_weighted_score_priority_queue_core.sv -----
`timescale 1ns / 1ps

module tb_weighted_score_priority_queue_core;
   import wsq_pkg::*;

   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam int         LIMIT_CYCLES = 400_000;
   localparam int         STALL_LEN    = 300;
   localparam int         MAX_PRINTS   = 40;

   // request field offsets
   localparam int REQ_ELEM_LSB    = 2;
   localparam int REQ_GRADE_LSB   = REQ_ELEM_LSB + ELEM_W;
   localparam int REQ_COURSES_LSB = REQ_GRADE_LSB + GRADE_W;

   // response field offsets
   localparam int RSP_GRADE_LSB   = ELEM_W;
   localparam int RSP_COURSES_LSB = RSP_GRADE_LSB + GRADE_W;
   localparam int RSP_PRIO_LSB    = RSP_COURSES_LSB + COURSES_W;
   localparam int RSP_COUNT_LSB   = RSP_PRIO_LSB + PRIO_W;
   localparam int RSP_EMPTY_BIT   = RSP_COUNT_LSB + OCC_W;
   localparam int RSP_STATUS_LSB  = RSP_EMPTY_BIT + 1;

   typedef struct {
      logic [1:0]           action;
      logic [ELEM_W-1:0]    elem;
      logic [GRADE_W-1:0]   grade;
      logic [COURSES_W-1:0] courses;
   } queue_req_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   weighted_score_priority_queue_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sorted-store shadow and register shadow
   logic [ELEM_W-1:0]    slot_elem_q    [DEPTH];
   logic [GRADE_W-1:0]   slot_grade_q   [DEPTH];
   logic [COURSES_W-1:0] slot_courses_q [DEPTH];
   logic [PRIO_W-1:0]    slot_score_q   [DEPTH];
   int                   fill_level = 0;
   logic [GRADE_W-1:0]   cfg_grade_scale  = GRADE_SCALE_RESET;
   logic [COURSES_W-1:0] cfg_course_scale = COURSE_SCALE_RESET;

   queue_req_type pending_reqs[$];
   rsp_type       expected_fronts[$];
   rsp_type       want;
   queue_req_type next_req;

   int   sent_count     = 0;
   int   accepted_count = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   int   send_gap_pct   = 36;
   int   accept_gap_pct = 84;
   int   stall_count    = 0;
   logic pressure_on    = 1'b0;
   logic req_taken      = 1'b0;

   function automatic int unsigned ratio_q16(input int unsigned num, input int unsigned den);
      if (den == 0)
         return 0;
      return (num << FRAC_W) / den;
   endfunction

   task automatic queue_apply(input logic [1:0] act, input logic [ELEM_W-1:0] e,
                              input logic [GRADE_W-1:0] g_in,
                              input logic [COURSES_W-1:0] c_in);
      int unsigned g;
      int unsigned c;
      int unsigned score;
      int          pos;
      int          i;
      rsp_type     r;
      logic [1:0]  st;
      st = ST_OK;
      g  = 32'(g_in);
      c  = 32'(c_in);
      if (act == ACT_ENQ) begin
         if (fill_level >= DEPTH) begin
            st = ST_FULL;
         end else begin
            if (g > cfg_grade_scale)
               g = 32'(cfg_grade_scale);
            if (c > cfg_course_scale)
               c = 32'(cfg_course_scale);
            score = (ratio_q16(g, 32'(cfg_grade_scale)) +
                     ratio_q16(c, 32'(cfg_course_scale))) >> 1;
            // go behind every entry of equal or higher score
            pos = 0;
            while (pos < fill_level && slot_score_q[pos] >= score)
               pos++;
            for (i = fill_level; i > pos; i--) begin
               slot_elem_q[i]    = slot_elem_q[i-1];
               slot_grade_q[i]   = slot_grade_q[i-1];
               slot_courses_q[i] = slot_courses_q[i-1];
               slot_score_q[i]   = slot_score_q[i-1];
            end
            slot_elem_q[pos]    = e;
            slot_grade_q[pos]   = g[GRADE_W-1:0];
            slot_courses_q[pos] = c[COURSES_W-1:0];
            slot_score_q[pos]   = score[PRIO_W-1:0];
            fill_level++;
         end
      end else if (act == ACT_DEQ) begin
         if (fill_level == 0) begin
            st = ST_EMPTY;
         end else begin
            for (i = 1; i < fill_level; i++) begin
               slot_elem_q[i-1]    = slot_elem_q[i];
               slot_grade_q[i-1]   = slot_grade_q[i];
               slot_courses_q[i-1] = slot_courses_q[i];
               slot_score_q[i-1]   = slot_score_q[i];
            end
            fill_level--;
         end
      end
      if (fill_level > 0) begin
         r.front_elem     = slot_elem_q[0];
         r.front_grade    = slot_grade_q[0];
         r.front_courses  = slot_courses_q[0];
         r.front_priority = slot_score_q[0];
      end else begin
         r.front_elem     = '0;
         r.front_grade    = '0;
         r.front_courses  = '0;
         r.front_priority = '0;
      end
      r.entry_count = fill_level[OCC_W-1:0];
      r.is_empty    = (fill_level == 0);
      r.status      = st;
      expected_fronts.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                  cycle_count, what, got, exp_val);
   endtask

   task automatic push_request(input logic [1:0] act, input logic [ELEM_W-1:0] e,
                               input logic [GRADE_W-1:0] g, input logic [COURSES_W-1:0] c);
      queue_req_type q;
      q.action  = act;
      q.elem    = e;
      q.grade   = g;
      q.courses = c;
      pending_reqs.push_back(q);
   endtask

   // bursts of enqueues, dequeues and mixed actions so the store fills and drains repeatedly
   task automatic queue_mixed_traffic(input int n);
      int                   made;
      int                   kind;
      int                   len;
      int                   k;
      logic [1:0]           act;
      logic [GRADE_W-1:0]   g;
      logic [COURSES_W-1:0] c;
      logic [GRADE_W-1:0]   tie_g;
      logic [COURSES_W-1:0] tie_c;
      made = 0;
      while (made < n) begin
         kind  = $urandom_range(0, 99);
         len   = $urandom_range(1, 20);
         tie_g = GRADE_W'($urandom_range(0, 1023));
         tie_c = COURSES_W'($urandom_range(0, 255));
         for (k = 0; k < len && made < n; k++) begin
            if (kind < 45)
               act = ACT_ENQ;
            else if (kind < 75)
               act = ACT_DEQ;
            else if (kind < 92)
               act = 2'($urandom_range(0, 3));
            else
               act = $urandom_range(0, 1) ? ACT_QUERY : ACT_UNUSED;
            case ($urandom_range(0, 3))
               0, 1: g = GRADE_W'($urandom_range(0, 1023));
               2: g = ($urandom_range(0, 1) ? 10'd1023 : cfg_grade_scale);
               default: g = tie_g;
            endcase
            case ($urandom_range(0, 3))
               0, 1: c = COURSES_W'($urandom_range(0, 255));
               2: c = ($urandom_range(0, 1) ? 8'd0 : cfg_course_scale);
               default: c = tie_c;
            endcase
            push_request(act, $urandom, g, c);
            made++;
         end
      end
   endtask

   task automatic wait_until_idle();
      while (pending_reqs.size() > 0 || sent_count != accepted_count ||
             expected_fronts.size() > 0)
         @(negedge clock);
   endtask

   // called at a falling edge with the block idle
   task automatic write_divisors(input logic [GRADE_W-1:0] mg, input logic [COURSES_W-1:0] tc);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_GRADE_SCALE;
      csr_wdata <= mg;
      @(negedge clock);
      cfg_grade_scale = mg;
      csr_addr  <= CSR_COURSE_SCALE;
      csr_wdata <= {{(CSR_DATA_W-COURSES_W){1'b0}}, tc};
      @(negedge clock);
      cfg_course_scale = tc;
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [GRADE_W-1:0] mg, input logic [COURSES_W-1:0] tc,
                            input int send_pct, input int accept_pct, input int n);
      wait_until_idle();
      repeat (4) @(negedge clock);
      write_divisors(mg, tc);
      send_gap_pct   = send_pct;
      accept_gap_pct = accept_pct;
      queue_mixed_traffic(n);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            next_req = pending_reqs.pop_front();
            req_tdata <= {{(REQ_DATA_W-REQ_FIELDS_W){1'b0}}, next_req.courses,
                          next_req.grade, next_req.elem, next_req.action};
            req_tvalid <= 1'b1;
            sent_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off once pressure is switched on
   always @(negedge clock) begin
      if (pressure_on && stall_count < STALL_LEN) begin
         rsp_tready  <= 1'b0;
         stall_count <= stall_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= accept_gap_pct);
      end
   end

   // request acceptance feeds the predictor
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         accepted_count++;
         queue_apply(req_tdata[1:0], req_tdata[REQ_ELEM_LSB +: ELEM_W],
                     req_tdata[REQ_GRADE_LSB +: GRADE_W],
                     req_tdata[REQ_COURSES_LSB +: COURSES_W]);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_fronts.size() == 0) begin
            report_mismatch("response with nothing expected, front_elem",
                            rsp_tdata[ELEM_W-1:0], 32'd0);
         end else begin
            want = expected_fronts.pop_front();
            if (rsp_tdata[ELEM_W-1:0] !== want.front_elem)
               report_mismatch("front_elem", rsp_tdata[ELEM_W-1:0], want.front_elem);
            if (rsp_tdata[RSP_GRADE_LSB +: GRADE_W] !== want.front_grade)
               report_mismatch("front_grade", 32'(rsp_tdata[RSP_GRADE_LSB +: GRADE_W]),
                               32'(want.front_grade));
            if (rsp_tdata[RSP_COURSES_LSB +: COURSES_W] !== want.front_courses)
               report_mismatch("front_courses",
                               32'(rsp_tdata[RSP_COURSES_LSB +: COURSES_W]),
                               32'(want.front_courses));
            if (rsp_tdata[RSP_PRIO_LSB +: PRIO_W] !== want.front_priority)
               report_mismatch("front_priority", 32'(rsp_tdata[RSP_PRIO_LSB +: PRIO_W]),
                               32'(want.front_priority));
            if (rsp_tdata[RSP_COUNT_LSB +: OCC_W] !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_tdata[RSP_COUNT_LSB +: OCC_W]),
                               32'(want.entry_count));
            if (rsp_tdata[RSP_EMPTY_BIT] !== want.is_empty)
               report_mismatch("is_empty", 32'(rsp_tdata[RSP_EMPTY_BIT]),
                               32'(want.is_empty));
            if (rsp_tdata[RSP_STATUS_LSB +: 2] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[RSP_STATUS_LSB +: 2]),
                               32'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("** weighted_score_priority_queue_core: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue, then clamping, extremes, ties and truncation at reset divisors
      push_request(ACT_QUERY, 32'h1234_5678, 10'd0, 8'd0);
      push_request(ACT_DEQ, 32'hFFFF_FFFF, 10'd1023, 8'd255);
      push_request(ACT_UNUSED, 32'h0, 10'd512, 8'd128);
      push_request(ACT_ENQ, 32'hFFFF_FFFF, 10'd1023, 8'd255);
      push_request(ACT_ENQ, 32'h0000_0000, 10'd0, 8'd0);
      push_request(ACT_ENQ, 32'hA5A5_0001, 10'd500, 8'd15);
      push_request(ACT_ENQ, 32'hA5A5_0002, 10'd500, 8'd15);
      push_request(ACT_ENQ, 32'hA5A5_0003, 10'd1000, 8'd0);
      push_request(ACT_ENQ, 32'h5A5A_0004, 10'd333, 8'd7);
      push_request(ACT_QUERY, 32'h0, 10'd0, 8'd0);
      push_request(ACT_UNUSED, 32'hFFFF_FFFF, 10'd1023, 8'd255);
      repeat (6) push_request(ACT_DEQ, 32'h0, 10'd0, 8'd0);
      push_request(ACT_DEQ, 32'h0, 10'd0, 8'd0);
      push_request(ACT_ENQ, 32'h0F0F_0F0F, 10'd999, 8'd29);

      run_phase(10'd1023, 8'd255, 36, 84, 100);
      run_phase(10'd1, 8'd1, 36, 84, 100);
      pressure_on = 1'b1;
      run_phase(10'd0, 8'd0, 84, 36, 100);
      run_phase(GRADE_W'($urandom_range(1, 1023)), COURSES_W'($urandom_range(1, 255)),
                84, 36, 100);
      run_phase(10'd1023, 8'd0, 0, 0, 100);
      run_phase(GRADE_W'($urandom_range(1, 1023)), COURSES_W'($urandom_range(1, 255)),
                0, 0, 100);

      wait_until_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("** weighted_score_priority_queue_core: PASSED **");
      else
         $display("** weighted_score_priority_queue_core: FAILED **");
      $finish;
   end

endmodule
